// ===== hdl/swr_pkg.sv =====
// Shared types and constants for the sliding-window reorder receiver.
package swr_pkg;

  // Fixed widths of the external fields.
  localparam int SEQNO_PORT_BITS   = 8;
  localparam int PAYLOAD_PORT_BITS = 32;

  // Upper limits of the configurable internal widths.
  localparam int SEQ_MAX_BITS = 16;
  localparam int PAY_MAX_BITS = 64;

  typedef enum logic [1:0] {
    FUNC_DATA     = 2'd0,
    FUNC_QUENCH   = 2'd1,
    FUNC_UNQUENCH = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    KIND_ACK      = 2'd0,
    KIND_DELIVER  = 2'd1,
    KIND_QUENCH   = 2'd2,
    KIND_UNQUENCH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK
  } state_t;

  // Control part of one result leaving the sequencer.
  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  last;
  } res_t;

endpackage

// ===== hdl/swr_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module swr_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/swr_ctrl.sv =====
// Sequencer: window test, reorder-table update and in-order delivery walk.
module swr_ctrl #(
  parameter int WINDOW       = 8,
  parameter int SEQ_BITS     = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [1:0]              func,
  input  logic [SEQ_BITS-1:0]     seq,
  input  logic [PAYLOAD_BITS-1:0] pay,
  output logic                    busy,
  output logic                    ram_we,
  output logic [SEQ_BITS-1:0]     ram_waddr,
  output logic [PAYLOAD_BITS:0]   ram_wdata,
  output logic [SEQ_BITS-1:0]     ram_raddr,
  input  logic [PAYLOAD_BITS:0]   ram_rdata,
  output swr_pkg::res_t           res,
  output logic [SEQ_BITS-1:0]     res_seq,
  output logic [PAYLOAD_BITS-1:0] res_pay
);

  localparam int CntW = $clog2(WINDOW + 2);
  localparam logic [CntW-1:0] CntMax = CntW'(WINDOW);
  // Wide enough for 2*WINDOW at any sequence width.
  localparam int CmpW = SEQ_BITS + 8;
  localparam logic [CmpW-1:0] NewMax = CmpW'(WINDOW);
  localparam logic [CmpW-1:0] OldMax = CmpW'(2 * WINDOW);

  swr_pkg::state_t state, state_next;

  logic [SEQ_BITS-1:0]     expected;
  logic [SEQ_BITS-1:0]     clr_addr;
  logic [CntW-1:0]         cnt;
  logic                    fwd;
  logic [PAYLOAD_BITS-1:0] hold_pay;
  swr_pkg::kind_t          pend_kind;
  logic [SEQ_BITS-1:0]     pend_seq;
  logic [PAYLOAD_BITS-1:0] pend_pay;

  logic [SEQ_BITS-1:0]     ahead;
  logic [SEQ_BITS-1:0]     behind;
  logic                    is_new;
  logic                    is_old;
  logic                    accept_new;
  logic                    full_eff;
  logic [PAYLOAD_BITS-1:0] pay_eff;
  logic                    cont;

  assign ahead  = seq - expected;
  assign behind = expected - seq;
  assign is_new = (CmpW'(ahead) <= NewMax);
  assign is_old = (behind != '0) && (CmpW'(behind) <= OldMax);

  // The first lookup may hit the slot written at accept: forward it.
  assign full_eff = fwd ? 1'b1 : ram_rdata[PAYLOAD_BITS];
  assign pay_eff  = fwd ? hold_pay : ram_rdata[PAYLOAD_BITS-1:0];
  assign cont     = full_eff && (cnt <= CntMax);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swr_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    ram_we     = 1'b0;
    ram_waddr  = clr_addr;
    ram_wdata  = '0;
    ram_raddr  = expected;
    res.valid  = 1'b0;
    res.kind   = swr_pkg::KIND_ACK;
    res.last   = 1'b1;
    res_seq    = '0;
    res_pay    = '0;
    accept_new = 1'b0;
    unique case (state)
      swr_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr == '1) begin
          state_next = swr_pkg::ST_IDLE;
        end
      end
      swr_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (func)
            swr_pkg::FUNC_QUENCH: begin
              res.valid = 1'b1;
              res.kind  = swr_pkg::KIND_QUENCH;
            end
            swr_pkg::FUNC_UNQUENCH: begin
              res.valid = 1'b1;
              res.kind  = swr_pkg::KIND_UNQUENCH;
            end
            swr_pkg::FUNC_DATA: begin
              if (is_new) begin
                accept_new = 1'b1;
                ram_we     = 1'b1;
                ram_waddr  = seq;
                ram_wdata  = {1'b1, pay};
                state_next = swr_pkg::ST_CHECK;
              end else if (is_old) begin
                res.valid = 1'b1;
                res_seq   = seq;
              end
            end
            default: begin
              // drop unused function codes
            end
          endcase
        end
      end
      swr_pkg::ST_CHECK: begin
        // Emit the pending item; its last flag follows from the slot just read.
        res.valid = 1'b1;
        res.kind  = pend_kind;
        res.last  = !cont;
        res_seq   = pend_seq;
        res_pay   = pend_pay;
        ram_raddr = expected + 1'b1;
        if (cont) begin
          ram_we    = 1'b1;
          ram_waddr = expected;
          ram_wdata = '0;
        end else begin
          state_next = swr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swr_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected <= SEQ_BITS'(1);
      clr_addr <= '0;
      cnt      <= '0;
      fwd      <= 1'b0;
    end else begin
      if (state == swr_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (accept_new) begin
        fwd <= (seq == expected);
        cnt <= '0;
      end else if (state == swr_pkg::ST_CHECK) begin
        fwd <= 1'b0;
        if (cont) begin
          expected <= expected + 1'b1;
          cnt      <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_new) begin
      hold_pay  <= pay;
      pend_kind <= swr_pkg::KIND_ACK;
      pend_seq  <= seq;
      pend_pay  <= '0;
    end else if ((state == swr_pkg::ST_CHECK) && cont) begin
      pend_kind <= swr_pkg::KIND_DELIVER;
      pend_seq  <= expected;
      pend_pay  <= pay_eff;
    end
  end

endmodule

// ===== hdl/sliding_window_reorder_receiver.sv =====
// Top level of the sliding-window reorder receiver.
//
// Receive end of a sliding-window link. An item is taken when start is high
// and busy is low. Network data 0..WINDOW ahead of the expected number is
// acked and stored in a reorder table held in one RAM; stored payloads that
// are now in order are then delivered. Data 1..2*WINDOW behind is only
// acked, other numbers are dropped; app quench and unquench are forwarded.
// Each result appears on the result ports for one cycle with strobe high,
// and last marks the final result of an item; the receiver cannot stall.
// A new data item keeps busy high while its ack and its D deliveries go
// out (D at most WINDOW+1), paced by one table read per delivery; other
// items leave busy low. After reset the RAM is cleared one entry a
// cycle with busy high.
module sliding_window_reorder_receiver #(
  parameter int WINDOW       = 8,
  parameter int SEQ_BITS     = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  output logic                                     busy,
  input  logic [1:0]                               func,
  input  logic [swr_pkg::SEQNO_PORT_BITS-1:0]      seqno,
  input  logic [swr_pkg::PAYLOAD_PORT_BITS-1:0]    payload,
  output logic                                     strobe,
  output logic [1:0]                               kind,
  output logic [swr_pkg::SEQNO_PORT_BITS-1:0]      out_seqno,
  output logic [swr_pkg::PAYLOAD_PORT_BITS-1:0]    out_payload,
  output logic                                     last
);

  localparam int SeqMax  = swr_pkg::SEQ_MAX_BITS;
  localparam int PayMax  = swr_pkg::PAY_MAX_BITS;
  localparam int SeqPort = swr_pkg::SEQNO_PORT_BITS;
  localparam int PayPort = swr_pkg::PAYLOAD_PORT_BITS;

  logic [SeqMax-1:0]       seq_in_wide;
  logic [PayMax-1:0]       pay_in_wide;
  logic [SEQ_BITS-1:0]     seq_in;
  logic [PAYLOAD_BITS-1:0] pay_in;

  logic                    ram_we;
  logic [SEQ_BITS-1:0]     ram_waddr;
  logic [PAYLOAD_BITS:0]   ram_wdata;
  logic [SEQ_BITS-1:0]     ram_raddr;
  logic [PAYLOAD_BITS:0]   ram_rdata;

  swr_pkg::res_t           res;
  logic [SEQ_BITS-1:0]     res_seq;
  logic [PAYLOAD_BITS-1:0] res_pay;
  logic [SeqMax-1:0]       res_seq_wide;
  logic [PayMax-1:0]       res_pay_wide;

  // Keep only the low bits that the sequence space and payload width use.
  assign seq_in_wide = SeqMax'(seqno);
  assign pay_in_wide = PayMax'(payload);
  assign seq_in      = seq_in_wide[SEQ_BITS-1:0];
  assign pay_in      = pay_in_wide[PAYLOAD_BITS-1:0];

  swr_ram #(
    .WIDTH(PAYLOAD_BITS + 1),
    .DEPTH(1 << SEQ_BITS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  swr_ctrl #(
    .WINDOW      (WINDOW),
    .SEQ_BITS    (SEQ_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .func     (func),
    .seq      (seq_in),
    .pay      (pay_in),
    .busy     (busy),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .res      (res),
    .res_seq  (res_seq),
    .res_pay  (res_pay)
  );

  assign res_seq_wide = SeqMax'(res_seq);
  assign res_pay_wide = PayMax'(res_pay);

  // Register the result ports.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    kind        <= res.kind;
    last        <= res.last;
    out_seqno   <= res_seq_wide[SeqPort-1:0];
    out_payload <= res_pay_wide[PayPort-1:0];
  end

endmodule

// ===== bench/swr_checker.sv =====
// Result checker for the sliding-window reorder receiver: predicts and compares every result.
`timescale 1ns / 1ps
module swr_reorder_checker #(
  parameter int WINDOW       = 8,
  parameter int SEQ_BITS     = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  func,
  input  logic [7:0]  seqno,
  input  logic [31:0] payload,
  input  logic        strobe,
  input  logic [1:0]  kind,
  input  logic [7:0]  out_seqno,
  input  logic [31:0] out_payload,
  input  logic        last,
  output int          failures,
  output int          pending,
  output int          checked,
  output int          delivered
);

  localparam int SEQ_SPACE = 1 << SEQ_BITS;
  localparam int SEQ_MASK  = SEQ_SPACE - 1;
  localparam logic [31:0] PAY_MASK =
    (PAYLOAD_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << PAYLOAD_BITS) - 64'd1);

  typedef struct packed {
    swr_pkg::kind_t kind;
    logic [7:0]     seqno;
    logic [31:0]    payload;
    logic           last;
  } reply_t;

  reply_t      pending_replies[$];
  int unsigned next_seq;
  logic        slot_full [SEQ_SPACE];
  logic [31:0] slot_pay  [SEQ_SPACE];
  int          fail_count;
  int          reply_count;
  int          deliver_count;

  initial begin
    fail_count    = 0;
    reply_count   = 0;
    deliver_count = 0;
    failures      = 0;
    pending       = 0;
    checked       = 0;
    delivered     = 0;
  end

  // Work out the results one accepted item causes and queue them in order.
  task automatic forecast_replies(input logic [1:0] f, input logic [7:0] s,
                                  input logic [31:0] p);
    int unsigned sq;
    int unsigned ahead;
    int unsigned behind;
    int          queued_before;
    reply_t      r;
    queued_before = pending_replies.size();
    r = '0;
    case (f)
      swr_pkg::FUNC_QUENCH: begin
        r.kind = swr_pkg::KIND_QUENCH;
        pending_replies.push_back(r);
      end
      swr_pkg::FUNC_UNQUENCH: begin
        r.kind = swr_pkg::KIND_UNQUENCH;
        pending_replies.push_back(r);
      end
      swr_pkg::FUNC_DATA: begin
        sq     = s & SEQ_MASK;
        ahead  = (sq - next_seq) & SEQ_MASK;
        behind = (next_seq - sq) & SEQ_MASK;
        // new test wins where the two ranges overlap
        if (ahead <= WINDOW) begin
          r.kind  = swr_pkg::KIND_ACK;
          r.seqno = 8'(sq);
          pending_replies.push_back(r);
          slot_full[sq] = 1'b1;
          slot_pay[sq]  = p & PAY_MASK;
          for (int i = 0; i <= WINDOW; i++) begin
            if (!slot_full[next_seq]) break;
            slot_full[next_seq] = 1'b0;
            r.kind    = swr_pkg::KIND_DELIVER;
            r.seqno   = 8'(next_seq);
            r.payload = slot_pay[next_seq];
            pending_replies.push_back(r);
            next_seq = (next_seq + 1) & SEQ_MASK;
          end
        end else if (behind >= 1 && behind <= 2 * WINDOW) begin
          r.kind  = swr_pkg::KIND_ACK;
          r.seqno = 8'(sq);
          pending_replies.push_back(r);
        end
      end
      default: ;
    endcase
    // mark the final result of this item
    if (pending_replies.size() > queued_before) begin
      r = pending_replies.pop_back();
      r.last = 1'b1;
      pending_replies.push_back(r);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      next_seq = 1 & SEQ_MASK;
      for (int i = 0; i < SEQ_SPACE; i++) slot_full[i] = 1'b0;
      pending_replies.delete();
    end else begin
      if (start && !busy) forecast_replies(func, seqno, payload);
      if (strobe) begin
        reply_count++;
        if (pending_replies.size() == 0) begin
          $display({"%0t: result with nothing expected: expected none, ",
                    "actual kind %0d seqno %h payload %h last %b"},
                   $time, kind, out_seqno, out_payload, last);
          fail_count++;
        end else begin
          want = pending_replies.pop_front();
          if (want.kind == swr_pkg::KIND_DELIVER) deliver_count++;
          compare_field("kind", 32'(want.kind), 32'(kind));
          compare_field("out_seqno", 32'(want.seqno), 32'(out_seqno));
          compare_field("out_payload", want.payload, out_payload);
          compare_field("last", 32'(want.last), 32'(last));
        end
      end
    end
    failures  <= fail_count;
    pending   <= pending_replies.size();
    checked   <= reply_count;
    delivered <= deliver_count;
  end

endmodule

// ===== bench/tb_sliding_window_reorder_receiver.sv =====
// Testbench top for the sliding-window reorder receiver: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_sliding_window_reorder_receiver;

  localparam int WINDOW       = 8;
  localparam int SEQ_BITS     = 8;
  localparam int PAYLOAD_BITS = 32;
  localparam int ITEM_TARGET  = 460;
  localparam int PHASE_ITEMS  = 60;
  localparam int STALL_LIMIT  = 2000;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        start   = 1'b0;
  logic [1:0]  func    = swr_pkg::FUNC_DATA;
  logic [7:0]  seqno   = '0;
  logic [31:0] payload = '0;
  logic        busy;
  logic        strobe;
  logic [1:0]  kind;
  logic [7:0]  out_seqno;
  logic [31:0] out_payload;
  logic        last;

  int mismatches;
  int outstanding;
  int checked;
  int delivered;

  int         gap_pct      = 0;
  int         useful_items = 0;
  int         all_items    = 0;
  int         stall_cycles = 0;
  logic [7:0] window_base  = 8'd1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sliding_window_reorder_receiver #(
    .WINDOW(WINDOW), .SEQ_BITS(SEQ_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)
  ) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .seqno(seqno), .payload(payload),
    .strobe(strobe), .kind(kind), .out_seqno(out_seqno),
    .out_payload(out_payload), .last(last)
  );

  swr_reorder_checker #(
    .WINDOW(WINDOW), .SEQ_BITS(SEQ_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)
  ) checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .seqno(seqno), .payload(payload),
    .strobe(strobe), .kind(kind), .out_seqno(out_seqno),
    .out_payload(out_payload), .last(last),
    .failures(mismatches), .pending(outstanding),
    .checked(checked), .delivered(delivered)
  );

  // Count cycles in which no item and no result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog: nothing moved for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int phase_gap(input int ph);
    case (ph)
      1:       return 47;
      3:       return 37;
      default: return 0;
    endcase
  endfunction

  // Present one item and hold it until busy is seen low.
  task automatic send_item(input logic [1:0] f, input logic [7:0] s,
                           input logic [31:0] p, input bit useful);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    func    <= f;
    seqno   <= s;
    payload <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    all_items++;
    if (useful) useful_items++;
  endtask

  // Hold the sender until every expected result has come out.
  task automatic drain_replies();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Items outside the current window: app controls, spare code, old and far numbers.
  task automatic send_noise();
    logic [7:0]  s;
    logic [31:0] p;
    s = 8'($urandom);
    p = $urandom;
    case ($urandom_range(4))
      0: send_item(swr_pkg::FUNC_QUENCH, s, p, 1'b1);
      1: send_item(swr_pkg::FUNC_UNQUENCH, s, p, 1'b1);
      2: send_item(FUNC_SPARE, s, p, 1'b0);
      3: send_item(swr_pkg::FUNC_DATA,
                   window_base - 8'($urandom_range(2 * WINDOW, 1)), p, 1'b1);
      default: send_item(swr_pkg::FUNC_DATA,
                         window_base + 8'($urandom_range(256 - 2 * WINDOW - 1,
                                                         2 * WINDOW + 2)),
                         p, 1'b0);
    endcase
  endtask

  initial begin
    int k;
    int i;
    int j;
    int t;
    int pass_no;
    int ph;
    int last_ph;
    bit lossy;
    int order [WINDOW+1];

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_item(swr_pkg::FUNC_QUENCH, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    send_item(swr_pkg::FUNC_UNQUENCH, 8'h00, 32'h0000_0000, 1'b1);
    send_item(FUNC_SPARE, 8'h5A, 32'h1234_5678, 1'b0);
    send_item(swr_pkg::FUNC_DATA, 8'd1, 32'h0000_0000, 1'b1);
    send_item(swr_pkg::FUNC_DATA, 8'd4, 32'hFFFF_FFFF, 1'b1);
    // duplicate of a stored number overwrites its payload
    send_item(swr_pkg::FUNC_DATA, 8'd4, 32'hA5A5_5A5A, 1'b1);
    send_item(swr_pkg::FUNC_DATA, 8'd3, $urandom, 1'b1);
    send_item(swr_pkg::FUNC_DATA, 8'd2, $urandom, 1'b1);
    send_item(swr_pkg::FUNC_DATA, 8'd4, $urandom, 1'b1);
    send_item(swr_pkg::FUNC_DATA, 8'd5 - 8'(2 * WINDOW), $urandom, 1'b1);
    send_item(swr_pkg::FUNC_DATA, 8'd5 - 8'(2 * WINDOW + 1), $urandom, 1'b0);
    send_item(swr_pkg::FUNC_DATA, 8'd5 + 8'(WINDOW + 1), $urandom, 1'b0);
    // fill the whole window backwards so the last item releases a full burst
    for (i = WINDOW; i >= 0; i--)
      send_item(swr_pkg::FUNC_DATA, 8'd5 + 8'(i), $urandom, 1'b1);
    window_base = 8'd5 + 8'(WINDOW + 1);
    drain_replies();

    last_ph = -1;
    while (useful_items < ITEM_TARGET) begin
      ph = (useful_items / PHASE_ITEMS) % 4;
      if (ph != last_ph) begin
        drain_replies();
        gap_pct = phase_gap(ph);
        last_ph = ph;
      end
      k = $urandom_range(WINDOW + 1, 1);
      for (i = 0; i < k; i++) order[i] = i;
      for (i = k - 1; i > 0; i--) begin
        j = $urandom_range(i, 0);
        t = order[i];
        order[i] = order[j];
        order[j] = t;
      end
      // a lossy pass drops the head of the block; the retry resends all of it
      lossy = (k > 1) && ($urandom_range(7) == 0);
      for (pass_no = lossy ? 0 : 1; pass_no < 2; pass_no++) begin
        for (i = 0; i < k; i++) begin
          if ($urandom_range(3) == 0) send_noise();
          if (pass_no == 0 && order[i] == 0) continue;
          send_item(swr_pkg::FUNC_DATA, window_base + 8'(order[i]), $urandom, 1'b1);
        end
      end
      window_base = window_base + 8'(k);
    end

    drain_replies();
    repeat (2 * WINDOW + 4) @(posedge clk);

    $display("Drove %0d items (%0d with results), checked %0d results, %0d of them deliveries.",
             all_items, useful_items, checked, delivered);
    $display("Covered out-of-order blocks, lost heads, duplicates, old and far numbers,");
    $display("app controls, the spare code and idle phases of 0, 47 and 37 percent.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
